### rtl/core/tscm_pkg.sv
// Shared constants and types for the calibrated touch sample mapper.
package tscm_pkg;

  localparam int SCREEN_WIDTH  = 800;
  localparam int SCREEN_HEIGHT = 480;

  localparam int COORD_W = 12;
  localparam int SIZE_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * COORD_W;
  localparam int CNT_W   = $clog2(COORD_W);
  localparam int IDX_W   = 3;
  localparam int IN_W    = 40;
  localparam int OUT_W   = 32;

  localparam logic [IDX_W-1:0] REG_CAL_X_LOW   = 3'd0;
  localparam logic [IDX_W-1:0] REG_CAL_X_HIGH  = 3'd1;
  localparam logic [IDX_W-1:0] REG_CAL_Y_LOW   = 3'd2;
  localparam logic [IDX_W-1:0] REG_CAL_Y_HIGH  = 3'd3;
  localparam logic [IDX_W-1:0] REG_INVERT_X    = 3'd4;
  localparam logic [IDX_W-1:0] REG_INVERT_Y    = 3'd5;
  localparam logic [IDX_W-1:0] REG_RAW_PASS    = 3'd6;
  localparam logic [IDX_W-1:0] REG_PRESS_THR   = 3'd7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV,
    ST_DONE
  } tscm_state_t;

endpackage

### rtl/core/touch_sample_calibrated_mapper.sv
// Calibrated touch mapper: pen detect, linear axis mapping with bit-serial divider.
// Released or raw-mode items go from IDLE straight to DONE; mapped items run a setup step
// per axis plus 12 restoring-divider steps where a quotient is needed (one shared divider).
// The block works on one item at a time; the next item is taken once the result
// is in the output register, so a waiting result does not block acceptance.
// Reset (rst, synchronous): calibration registers to defaults, held point to 0.
module touch_sample_calibrated_mapper
  import tscm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // pen_irq_level[0], pressure_z1[12:1], sample_x[24:13], sample_y[36:25], zero[39:37]
  input  logic [IN_W-1:0]      s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // touched[0], point_x[12:1], point_y[24:13], cal_fault[25], zero[31:26]
  output logic [OUT_W-1:0]     m_tdata,
  input  logic                 cfg_we,
  input  logic [IDX_W-1:0]     cfg_index,
  input  logic [COORD_W-1:0]   cfg_data
);

  localparam logic [SIZE_W-1:0]  SIZE_X     = SIZE_W'(SCREEN_WIDTH);
  localparam logic [SIZE_W-1:0]  SIZE_Y     = SIZE_W'(SCREEN_HEIGHT);
  localparam logic [COORD_W-1:0] LAST_X     = COORD_W'(SCREEN_WIDTH - 1);
  localparam logic [COORD_W-1:0] LAST_Y     = COORD_W'(SCREEN_HEIGHT - 1);
  localparam logic [CNT_W-1:0]   LAST_STEP  = CNT_W'(COORD_W - 1);

  tscm_state_t state, state_next;

  logic [COORD_W-1:0] cal_x_low, cal_x_high, cal_y_low, cal_y_high, pressure_threshold;
  logic               invert_x, invert_y, raw_passthrough;
  logic [COORD_W-1:0] held_x, held_y;

  logic               pressed;
  logic [COORD_W-1:0] raw_x, raw_y;
  logic [COORD_W-1:0] res_x, res_y;
  logic               fault;
  logic               axis;

  logic [COORD_W-1:0] rem;
  logic [COORD_W-1:0] dq;
  logic [COORD_W-1:0] div_span;
  logic [CNT_W-1:0]   count;

  logic [COORD_W-1:0] out_x, out_y;
  logic               out_touched, out_fault;

  // input fields
  logic               in_irq;
  logic [COORD_W-1:0] in_z1, in_x, in_y;
  logic               in_pressed;

  // control
  logic accept, out_free, load_out, div_last;

  // axis setup
  logic [COORD_W-1:0] sel_raw, sel_lo, sel_hi, sel_last;
  logic [SIZE_W-1:0]  sel_size;
  logic               sel_inv;
  logic [COORD_W:0]   num;
  logic [COORD_W-1:0] span;
  logic               bad_span, num_le0, num_ge_span, setup_div;
  logic [COORD_W-1:0] setup_res;
  logic [PROD_W:0]    prod;

  // divider step
  logic [COORD_W:0]   rem_sh;
  logic               qbit;
  logic [COORD_W-1:0] rem_new;

  assign in_irq     = s_tdata[0];
  assign in_z1      = s_tdata[12:1];
  assign in_x       = s_tdata[24:13];
  assign in_y       = s_tdata[36:25];
  assign in_pressed = !in_irq && (in_z1 >= pressure_threshold);

  assign sel_raw  = axis ? raw_y : raw_x;
  assign sel_lo   = axis ? cal_y_low : cal_x_low;
  assign sel_hi   = axis ? cal_y_high : cal_x_high;
  assign sel_inv  = axis ? invert_y : invert_x;
  assign sel_size = axis ? SIZE_Y : SIZE_X;
  assign sel_last = axis ? LAST_Y : LAST_X;

  assign bad_span    = (sel_hi <= sel_lo);
  assign span        = sel_hi - sel_lo;
  assign num         = sel_inv ? ({1'b0, sel_hi} - {1'b0, sel_raw})
                               : ({1'b0, sel_raw} - {1'b0, sel_lo});
  assign num_le0     = num[COORD_W] || (num == '0);
  assign num_ge_span = (num[COORD_W-1:0] >= span);
  assign setup_div   = !bad_span && !num_le0 && !num_ge_span;
  assign setup_res   = (bad_span || num_le0) ? '0 : sel_last;
  assign prod        = num[COORD_W-1:0] * sel_size;

  assign rem_sh  = {rem, dq[COORD_W-1]};
  assign qbit    = (rem_sh >= {1'b0, div_span});
  assign rem_new = qbit ? COORD_W'(rem_sh - {1'b0, div_span}) : rem_sh[COORD_W-1:0];

  assign div_last = (count == LAST_STEP);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = (in_pressed && !raw_passthrough) ? ST_SETUP : ST_DONE;
        end
      end
      ST_SETUP: begin
        if (setup_div) begin
          state_next = ST_DIV;
        end else if (axis) begin
          state_next = ST_DONE;
        end
      end
      ST_DIV: begin
        if (div_last) begin
          state_next = axis ? ST_DONE : ST_SETUP;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_tready = 1'b0;
    load_out = 1'b0;
    unique case (state)
      ST_IDLE:  s_tready = 1'b1;
      ST_DONE:  load_out = out_free;
      default: ;
    endcase
  end

  assign out_free = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cal_x_low          <= 12'd200;
      cal_x_high         <= 12'd3900;
      cal_y_low          <= 12'd200;
      cal_y_high         <= 12'd3900;
      invert_x           <= 1'b0;
      invert_y           <= 1'b0;
      raw_passthrough    <= 1'b0;
      pressure_threshold <= 12'd100;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CAL_X_LOW:  cal_x_low          <= cfg_data;
        REG_CAL_X_HIGH: cal_x_high         <= cfg_data;
        REG_CAL_Y_LOW:  cal_y_low          <= cfg_data;
        REG_CAL_Y_HIGH: cal_y_high         <= cfg_data;
        REG_INVERT_X:   invert_x           <= cfg_data[0];
        REG_INVERT_Y:   invert_y           <= cfg_data[0];
        REG_RAW_PASS:   raw_passthrough    <= cfg_data[0];
        REG_PRESS_THR:  pressure_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // control state: axis select and divider step count
  always_ff @(posedge clk) begin
    if (rst) begin
      axis  <= 1'b0;
      count <= '0;
    end else begin
      if (accept) begin
        axis <= 1'b0;
      end else if (state == ST_SETUP && !setup_div) begin
        axis <= 1'b1;
      end else if (state == ST_DIV && div_last) begin
        axis <= 1'b1;
      end
      if (state == ST_DIV && !div_last) begin
        count <= count + 1'b1;
      end else begin
        count <= '0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      pressed <= in_pressed;
      raw_x   <= in_x;
      raw_y   <= in_y;
      res_x   <= in_x;
      res_y   <= in_y;
      fault   <= 1'b0;
    end
    if (state == ST_SETUP) begin
      if (bad_span) begin
        fault <= 1'b1;
      end
      if (setup_div) begin
        rem      <= prod[PROD_W-1:COORD_W];
        dq       <= prod[COORD_W-1:0];
        div_span <= span;
      end else if (axis) begin
        res_y <= setup_res;
      end else begin
        res_x <= setup_res;
      end
    end
    if (state == ST_DIV) begin
      rem <= rem_new;
      dq  <= {dq[COORD_W-2:0], qbit};
      if (div_last) begin
        if (axis) begin
          res_y <= {dq[COORD_W-2:0], qbit};
        end else begin
          res_x <= {dq[COORD_W-2:0], qbit};
        end
      end
    end
  end

  // output register and held point
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      held_x   <= '0;
      held_y   <= '0;
    end else begin
      if (load_out) begin
        m_tvalid <= 1'b1;
        if (pressed) begin
          held_x <= res_x;
          held_y <= res_y;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_touched <= pressed;
      out_x       <= pressed ? res_x : held_x;
      out_y       <= pressed ? res_y : held_y;
      out_fault   <= pressed && fault;
    end
  end

  assign m_tdata = {6'd0, out_fault, out_y, out_x, out_touched};

  a_count_only_in_div: assert property (@(posedge clk) disable iff (rst)
    (state != ST_DIV) |-> (count == '0))
    else $error("divider step count active outside divide");

  a_rem_below_span: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (rem < div_span))
    else $error("divider remainder not below span");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != ST_IDLE))
    else $error("accepted item did not start processing");

  a_released_no_fault: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !out_touched) |-> !out_fault)
    else $error("released result carries calibration fault");

endmodule
